@@ sv/bpc_pkg.sv @@
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every other file imports this package.
package bpc_pkg;

	// configuration port
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1    = 4'd0,
		REG_C2    = 4'd1,
		REG_C3    = 4'd2,
		REG_C4    = 4'd3,
		REG_C5    = 4'd4,
		REG_C6    = 4'd5,
		REG_C7    = 4'd6,
		REG_SHAPE = 4'd7
	} cfg_reg_t;

	// calibration set as seen by the datapath (shift bytes already clamped)
	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
		logic [15:0] c7;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [3:0]  c;
		logic [3:0]  d;
	} coef_t;

	// datapath widths (Q16 values, signed)
	localparam int X_W        = 17;          // raw temp minus C5
	localparam int SQ_W       = 32;          // X*X
	localparam int SQZ_W      = 40;          // X*X*Z
	localparam int DUT_W      = 44;          // dUT
	localparam int DUT_SPLIT  = 22;          // low half of dUT for partial products
	localparam int PP_W       = 40;          // 22-bit x 17-bit partial product
	localparam int MP_W       = 62;          // recombined dUT x coefficient
	localparam int T_W        = 46;          // temperature, Q16
	localparam int SENS_W     = 51;          // sensitivity, Q16
	localparam int SENS_SPLIT = 25;          // low part of SENS for partial products
	localparam int OFF_W      = 49;          // offset, Q16
	localparam int Q_W        = 43;          // 26-bit x 17-bit partial product
	localparam int PSUM_W     = 68;          // SENS x (D1 - 7168)
	localparam int X2_W       = 55;
	localparam int X10_W      = 59;          // X2 * 10
	localparam int P_W        = 55;          // pressure, Q16
	localparam int TI_W       = T_W - 16;    // whole tenths of degC
	localparam int PI_W       = P_W - 16;    // whole tenths of hPa

	localparam logic signed [16:0]    PRESS_BIAS = 17'sd7168;
	localparam logic signed [16:0]    OFF_BIAS   = 17'sd1024;
	localparam logic signed [T_W-1:0] TEMP_BASE  = 46'sd16384000;   // 250.0 in Q16

	localparam int PIPE_DEPTH = 11;
	localparam int INF_W      = 4;           // holds 0..PIPE_DEPTH

endpackage

@@ sv/bpc_dut.sv @@
// Stages 1-4: temperature difference, square term and dUT.
// Depends on bpc_pkg.
module bpc_dut
	import bpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  coef_t                   coef,
	input  logic                    in_vld,
	output logic                    in_rdy,
	input  logic [15:0]             d2,
	input  logic [15:0]             d1,
	output logic                    out_vld,
	input  logic                    out_rdy,
	output logic signed [DUT_W-1:0] dut,
	output logic signed [16:0]      d1b
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic signed [X_W-1:0]   x_s1, x_s2, x_s3;
	logic [7:0]              z_s1, z_s2;
	logic signed [16:0]      d1b_s1, d1b_s2, d1b_s3, d1b_s4;
	logic [SQ_W-1:0]         sq_s2;
	logic [SQZ_W-1:0]        sqz_s3;
	logic signed [DUT_W-1:0] dut_s4;

	logic signed [2*X_W-1:0] xx;
	logic [SQZ_W+1:0]        sqz_sh;
	logic signed [DUT_W-1:0] x_q16;

	// bubble-collapsing advance chain
	assign adv_s4 = ~vld_s4 | out_rdy;
	assign adv_s3 = ~vld_s3 | adv_s4;
	assign adv_s2 = ~vld_s2 | adv_s3;
	assign adv_s1 = ~vld_s1 | adv_s2;
	assign in_rdy = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_vld;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		xx     = x_s1 * x_s1;
		sqz_sh = {sqz_s3, 2'b00} >> coef.c;
		x_q16  = DUT_W'(x_s3) <<< 16;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x_s1   <= signed'({1'b0, d2}) - signed'({1'b0, coef.c5});
			z_s1   <= (d2 < coef.c5) ? coef.b : coef.a;
			d1b_s1 <= signed'({1'b0, d1}) - PRESS_BIAS;
		end
		if (adv_s2) begin
			sq_s2  <= xx[SQ_W-1:0];   // X*X < 2^32
			x_s2   <= x_s1;
			z_s2   <= z_s1;
			d1b_s2 <= d1b_s1;
		end
		if (adv_s3) begin
			sqz_s3 <= sq_s2 * z_s2;
			x_s3   <= x_s2;
			d1b_s3 <= d1b_s2;
		end
		if (adv_s4) begin
			dut_s4 <= x_q16 - signed'(DUT_W'(sqz_sh));
			d1b_s4 <= d1b_s3;
		end
	end

	assign out_vld = vld_s4;
	assign dut     = dut_s4;
	assign d1b     = d1b_s4;

endmodule

@@ sv/bpc_poly.sv @@
// Stages 5-7: dUT times C6, C4-1024 and C3 as split partial products,
// then temperature, offset and sensitivity. Depends on bpc_pkg.
module bpc_poly
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  coef_t                    coef,
	input  logic                     in_vld,
	output logic                     in_rdy,
	input  logic signed [DUT_W-1:0]  dut,
	input  logic signed [16:0]       d1b,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output logic signed [T_W-1:0]    t,
	output logic signed [SENS_W-1:0] sens,
	output logic signed [OFF_W-1:0]  off,
	output logic signed [16:0]       d1b_out
);

	logic vld_s5, vld_s6, vld_s7;
	logic adv_s5, adv_s6, adv_s7;

	logic signed [PP_W-1:0]   p6l_s5, p6h_s5, p4l_s5, p4h_s5, p3l_s5, p3h_s5;
	logic signed [DUT_W-1:0]  dsh_s5, dsh_s6;
	logic signed [16:0]       d1b_s5, d1b_s6, d1b_s7;
	logic signed [MP_W-1:0]   m6_s6, m4_s6, m3_s6;
	logic signed [T_W-1:0]    t_s7;
	logic signed [SENS_W-1:0] sens_s7;
	logic signed [OFF_W-1:0]  off_s7;

	logic signed [DUT_SPLIT:0]         dut_lo;
	logic signed [DUT_W-DUT_SPLIT-1:0] dut_hi;
	logic signed [16:0]                c6s, c4m, c3s;
	logic signed [OFF_W-1:0]           off_in;

	assign adv_s7 = ~vld_s7 | out_rdy;
	assign adv_s6 = ~vld_s6 | adv_s7;
	assign adv_s5 = ~vld_s5 | adv_s6;
	assign in_rdy = adv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s5) vld_s5 <= in_vld;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	always_comb begin
		dut_lo = signed'({1'b0, dut[DUT_SPLIT-1:0]});
		dut_hi = dut[DUT_W-1:DUT_SPLIT];
		c6s    = signed'({1'b0, coef.c6});
		c3s    = signed'({1'b0, coef.c3});
		c4m    = signed'({1'b0, coef.c4}) - OFF_BIAS;
		off_in = OFF_W'(signed'({1'b0, coef.c2, 16'h0000})) + OFF_W'(m4_s6 >>> 14);
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			p6l_s5 <= dut_lo * c6s;
			p6h_s5 <= dut_hi * c6s;
			p4l_s5 <= dut_lo * c4m;
			p4h_s5 <= dut_hi * c4m;
			p3l_s5 <= dut_lo * c3s;
			p3h_s5 <= dut_hi * c3s;
			dsh_s5 <= dut >>> coef.d;
			d1b_s5 <= d1b;
		end
		if (adv_s6) begin
			m6_s6  <= (MP_W'(p6h_s5) <<< DUT_SPLIT) + MP_W'(p6l_s5);
			m4_s6  <= (MP_W'(p4h_s5) <<< DUT_SPLIT) + MP_W'(p4l_s5);
			m3_s6  <= (MP_W'(p3h_s5) <<< DUT_SPLIT) + MP_W'(p3l_s5);
			dsh_s6 <= dsh_s5;
			d1b_s6 <= d1b_s5;
		end
		if (adv_s7) begin
			t_s7    <= TEMP_BASE + T_W'(m6_s6 >>> 16) - T_W'(dsh_s6);
			sens_s7 <= SENS_W'(signed'({1'b0, coef.c1, 16'h0000})) + SENS_W'(m3_s6 >>> 10);
			off_s7  <= off_in <<< 2;
			d1b_s7  <= d1b_s6;
		end
	end

	assign out_vld = vld_s7;
	assign t       = t_s7;
	assign sens    = sens_s7;
	assign off     = off_s7;
	assign d1b_out = d1b_s7;

endmodule

@@ sv/bpc_press.sv @@
// Stages 8-11: SENS x (D1 - 7168) as split partial products, pressure,
// flooring to tenths, saturation and the output register. Depends on bpc_pkg.
module bpc_press
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  coef_t                    coef,
	input  logic                     in_vld,
	output logic                     in_rdy,
	input  logic signed [T_W-1:0]    t,
	input  logic signed [SENS_W-1:0] sens,
	input  logic signed [OFF_W-1:0]  off,
	input  logic signed [16:0]       d1b,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output logic [15:0]              temp_tenths,
	output logic [15:0]              press_tenths,
	output logic                     sat
);

	logic vld_s8, vld_s9, vld_s10, vld_s11;
	logic adv_s8, adv_s9, adv_s10, adv_s11;

	logic signed [Q_W-1:0]   ql_s8, qh_s8;
	logic signed [T_W-1:0]   t_s8, t_s9;
	logic signed [OFF_W-1:0] off_s8;
	logic signed [X2_W-1:0]  x2_s9;
	logic signed [P_W-1:0]   p_s10;
	logic signed [TI_W-1:0]  ti_s10;
	logic [15:0]             temp_s11, press_s11;
	logic                    sat_s11;

	logic signed [SENS_SPLIT:0]          sens_lo;
	logic signed [SENS_W-SENS_SPLIT-1:0] sens_hi;
	logic signed [PSUM_W-1:0]            psum;
	logic signed [X10_W-1:0]             x10;
	logic signed [PI_W-1:0]              pi;
	logic                                t_hi, t_lo, p_hi, p_lo;
	logic [15:0]                         temp_c, press_c;

	assign adv_s11 = ~vld_s11 | out_rdy;
	assign adv_s10 = ~vld_s10 | adv_s11;
	assign adv_s9  = ~vld_s9 | adv_s10;
	assign adv_s8  = ~vld_s8 | adv_s9;
	assign in_rdy  = adv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			if (adv_s8)  vld_s8  <= in_vld;
			if (adv_s9)  vld_s9  <= vld_s8;
			if (adv_s10) vld_s10 <= vld_s9;
			if (adv_s11) vld_s11 <= vld_s10;
		end
	end

	always_comb begin
		sens_lo = signed'({1'b0, sens[SENS_SPLIT-1:0]});
		sens_hi = sens[SENS_W-1:SENS_SPLIT];
		psum    = (PSUM_W'(qh_s8) <<< SENS_SPLIT) + PSUM_W'(ql_s8);
		x10     = (X10_W'(x2_s9) <<< 3) + (X10_W'(x2_s9) <<< 1);
		pi      = p_s10[P_W-1:16];
		// clamp checks: upper bits must all match the sign of the field
		t_hi    = ~ti_s10[TI_W-1] & (|ti_s10[TI_W-2:15]);
		t_lo    = ti_s10[TI_W-1] & ~(&ti_s10[TI_W-2:15]);
		p_lo    = pi[PI_W-1];
		p_hi    = ~pi[PI_W-1] & (|pi[PI_W-2:16]);
		if (t_hi)
			temp_c = 16'h7FFF;
		else if (t_lo)
			temp_c = 16'h8000;
		else
			temp_c = ti_s10[15:0];
		if (p_hi)
			press_c = 16'hFFFF;
		else if (p_lo)
			press_c = 16'h0000;
		else
			press_c = pi[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			ql_s8  <= sens_lo * d1b;
			qh_s8  <= sens_hi * d1b;
			t_s8   <= t;
			off_s8 <= off;
		end
		if (adv_s9) begin
			x2_s9 <= X2_W'(psum >>> 14) - X2_W'(off_s8);
			t_s9  <= t_s8;
		end
		if (adv_s10) begin
			p_s10  <= P_W'(x10 >>> 5) + P_W'(signed'({1'b0, coef.c7, 16'h0000}));
			ti_s10 <= TI_W'(t_s9 >>> 16);
		end
		if (adv_s11) begin
			temp_s11  <= temp_c;
			press_s11 <= press_c;
			sat_s11   <= t_hi | t_lo | p_hi | p_lo;
		end
	end

	assign out_vld      = vld_s11;
	assign temp_tenths  = temp_s11;
	assign press_tenths = press_s11;
	assign sat          = sat_s11;

endmodule

@@ sv/baro_temp_pressure_compensation.sv @@
// Top level of the barometric temperature/pressure compensation pipeline.
// Depends on bpc_pkg, bpc_dut, bpc_poly and bpc_press.
//
// Usage:
//  - s_axis: one beat per sample pair, tdata = raw temperature in 15:0,
//    raw pressure in 31:16.
//  - m_axis: one beat per sample pair, tdata = temperature in 0.1 degC
//    (signed) in 15:0, pressure in 0.1 hPa in 31:16; tuser = saturation flag.
//  - cfg: register writes (index 0..6 = C1..C7, 7 = shape bytes A:B:C:D).
//    Always ready. Write only while no sample is in flight; other indexes
//    are dropped. Shift bytes C and D saturate at 15.
//  - Pipeline: eleven register stages: dUT in four, polynomial terms in
//    three, pressure product and clamping in four.
//  - Throughput: one pair per cycle unless stalled; each stage is a few
//    adds or a set of parallel multipliers, none wider than 26 x 17 bits
//    (32 x 8 for X*X*Z).
//  - Stall: every stage has its own valid; empty stages keep filling while
//    m_axis_tready is low, so s_axis_tready drops only once the whole
//    pipeline is full behind a waiting result. Nothing is dropped or repeated.
//  - Reset: clears all stage valids and all calibration registers to zero.
module baro_temp_pressure_compensation
	import bpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// sample input
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // raw_temperature, raw_pressure
	// result output
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // temperature_tenths, pressure_tenths
	output logic                 m_axis_tuser,   // saturated
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
	logic [31:0] shape_q;
	coef_t       coef;

	logic                    v_dut, r_dut;
	logic signed [DUT_W-1:0] dut;
	logic signed [16:0]      d1b_a, d1b_b;

	logic                     v_poly, r_poly;
	logic signed [T_W-1:0]    t;
	logic signed [SENS_W-1:0] sens;
	logic signed [OFF_W-1:0]  off;

	logic [15:0]      temp_tenths, press_tenths;
	logic [INF_W-1:0] inflight_q;
	logic             in_acc, out_acc;

	assign cfg_ready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q    <= '0;
			c2_q    <= '0;
			c3_q    <= '0;
			c4_q    <= '0;
			c5_q    <= '0;
			c6_q    <= '0;
			c7_q    <= '0;
			shape_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_C1:    c1_q    <= cfg_data[15:0];
				REG_C2:    c2_q    <= cfg_data[15:0];
				REG_C3:    c3_q    <= cfg_data[15:0];
				REG_C4:    c4_q    <= cfg_data[15:0];
				REG_C5:    c5_q    <= cfg_data[15:0];
				REG_C6:    c6_q    <= cfg_data[15:0];
				REG_C7:    c7_q    <= cfg_data[15:0];
				REG_SHAPE: shape_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient bundle; shift bytes clamp to 15
	always_comb begin
		coef.c1 = c1_q;
		coef.c2 = c2_q;
		coef.c3 = c3_q;
		coef.c4 = c4_q;
		coef.c5 = c5_q;
		coef.c6 = c6_q;
		coef.c7 = c7_q;
		coef.a  = shape_q[31:24];
		coef.b  = shape_q[23:16];
		coef.c  = (|shape_q[15:12]) ? 4'hF : shape_q[11:8];
		coef.d  = (|shape_q[7:4]) ? 4'hF : shape_q[3:0];
	end

	bpc_dut u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.in_vld  (s_axis_tvalid),
		.in_rdy  (s_axis_tready),
		.d2      (s_axis_tdata[15:0]),
		.d1      (s_axis_tdata[31:16]),
		.out_vld (v_dut),
		.out_rdy (r_dut),
		.dut     (dut),
		.d1b     (d1b_a)
	);

	bpc_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.in_vld  (v_dut),
		.in_rdy  (r_dut),
		.dut     (dut),
		.d1b     (d1b_a),
		.out_vld (v_poly),
		.out_rdy (r_poly),
		.t       (t),
		.sens    (sens),
		.off     (off),
		.d1b_out (d1b_b)
	);

	bpc_press u_press (
		.clk          (clk),
		.arst_n       (arst_n),
		.coef         (coef),
		.in_vld       (v_poly),
		.in_rdy       (r_poly),
		.t            (t),
		.sens         (sens),
		.off          (off),
		.d1b          (d1b_b),
		.out_vld      (m_axis_tvalid),
		.out_rdy      (m_axis_tready),
		.temp_tenths  (temp_tenths),
		.press_tenths (press_tenths),
		.sat          (m_axis_tuser)
	);

	assign m_axis_tdata = {press_tenths, temp_tenths};

	// items in flight, for the checks below
	assign in_acc  = s_axis_tvalid & s_axis_tready;
	assign out_acc = m_axis_tvalid & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc & ~out_acc)
			inflight_q <= inflight_q + INF_W'(1);
		else if (out_acc & ~in_acc)
			inflight_q <= inflight_q - INF_W'(1);
	end

	// never more beats inside than register stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INF_W'(PIPE_DEPTH))
		else $error("pipeline holds more items than stages");

	// input backpressure only comes from a stalled result
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while output is free");

	// no result without an item inside
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !m_axis_tvalid)
		else $error("result presented with empty pipeline");

endmodule
